// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bblur_pkg.sv =====
// ----------------------------------------------------------------------------
// bblur_pkg
// Types, constants and divider reciprocals for the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

    localparam int CHAN_W        = 8;
    localparam int PIX_W         = 3 * CHAN_W;
    localparam int WIDTH_REG_W   = 11;
    localparam int HEIGHT_REG_W  = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int OUT_ROW_W     = 12;
    localparam int OUT_COL_W     = 10;
    localparam int IN_DATA_W     = 24;
    localparam int OUT_DATA_W    = 48;
    localparam int SUM_W         = 12;   // 9 * 255 + 4 fits
    localparam int CNT_W         = 4;    // neighbor count, 1..9
    localparam int RECIP_W       = 17;
    localparam int RECIP_SHIFT   = 16;
    localparam int PROD_W        = SUM_W + RECIP_W;

    localparam int IMAGE_WIDTH_RESET  = 640;
    localparam int IMAGE_HEIGHT_RESET = 480;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // red in the low byte, matching the stream packing
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    // ceil(2^16 / n): exact quotient for any dividend below 2^15
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/box_blur_3x3_rgb_core.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core
// 3x3 edge-clipped box blur over an RGB raster stream, round half up.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on s_axis in raster order, one per transaction. Every
//   blurred pixel leaves on m_axis once its 3x3 neighborhood is in, so the
//   last row and column come out with the inputs that complete them.
//   m_axis_tlast marks the final pixel of a frame, m_axis_tuser the last
//   result caused by one input pixel.
//   Frame size is set through cfg_we/cfg_index/cfg_data while idle; a write
//   restarts the frame at pixel (0,0).
//   A result reaches m_axis from the input that completes it through the
//   line-store read, window, sum and reciprocal multiply registers.
//   Throughput: one pixel per cycle while m_axis_tready is high. Results
//   drain one per cycle from the sum stage, so an input in the last column
//   or last row holds that stage until all of its results have left.
//   Reset empties the pipeline, zeroes the position counters and sets the
//   frame to 640 x 480. Line stores are not cleared.
//   When m_axis_tready is low, the pipeline fills (four stages) and
//   s_axis_tready then drops until the output moves again.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_blur_3x3_rgb_core
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pix_red, pix_green, pix_blue
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // blur_red, blur_green, blur_blue, out_row, out_col, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,   // frame_end
    output logic                  m_axis_tuser,   // last_of_run
    input  logic                  cfg_we,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RESET_W = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RESET;
    localparam int RESET_H = (IMAGE_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT :
                             IMAGE_HEIGHT_RESET;

    // ---------------- configuration and position counters ----------------
    logic [CW-1:0] last_col_reg, last_col_next;
    logic [RW-1:0] last_row_reg, last_row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [31:0]   cfg_w, cfg_h;
    logic          in_col_last, in_row_last;
    logic          s_fire;

    // ---------------- stage 1: line-store read ----------------
    rgb_t          prev_mem  [MAX_WIDTH];
    rgb_t          older_mem [MAX_WIDTH];
    rgb_t          prev_rd_reg, older_rd_reg;
    logic          s1_valid_reg, s1_valid_next;
    rgb_t          s1_pix_reg;
    logic [RW-1:0] s1_row_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_row_last_reg, s1_col_last_reg;
    logic          s1_byp_reg;
    rgb_t          s1_byp_prev_reg, s1_byp_older_reg;
    rgb_t          s1_prev, s1_older;
    logic          s1_adv, byp;

    // ---------------- stage 2: window and result sequencing ----------------
    rgb_t          win_reg [3][3];
    logic          s2_valid_reg, s2_valid_next;
    logic [RW-1:0] s2_row_reg;
    logic [CW-1:0] s2_col_reg;
    logic          s2_r_ge1_reg, s2_r_ge2_reg, s2_r_last_reg;
    logic          s2_c_ge1_reg, s2_c_ge2_reg, s2_c_last_reg;
    logic          s2_row_sel_reg, s2_row_sel_next;
    logic          s2_col_sel_reg, s2_col_sel_next;
    logic          s2_more_col, s2_more_row, s2_is_last;
    logic          s2_ready, s2_fire, s1_has_res;
    logic [2:0]    rmask, cmask;
    logic [1:0]    rcnt, ccnt;
    logic [CNT_W-1:0] s2_n;
    logic [SUM_W-1:0] rs_red [3];
    logic [SUM_W-1:0] rs_green [3];
    logic [SUM_W-1:0] rs_blue [3];
    logic [SUM_W-1:0] t_red, t_green, t_blue;
    logic [RW-1:0] s2_a;
    logic [CW-1:0] s2_b;

    // ---------------- stage 3: divide, output register ----------------
    logic             s3_valid_reg, s3_valid_next;
    logic [SUM_W-1:0] s3_red_reg, s3_green_reg, s3_blue_reg;
    logic [CNT_W-1:0] s3_n_reg;
    logic [OUT_ROW_W-1:0] s3_row_reg;
    logic [OUT_COL_W-1:0] s3_col_reg;
    logic             s3_fend_reg, s3_last_reg, s3_ready;
    logic [RECIP_W-1:0] s3_m;
    logic [PROD_W-1:0]  prod_red, prod_green, prod_blue;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic             out_fend_reg, out_last_reg, out_ready;

    // ======================= handshake chain =======================
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s3_ready      = !s3_valid_reg || out_ready;
    assign s2_fire       = s2_valid_reg && s3_ready;
    assign s2_ready      = !s2_valid_reg || (s3_ready && s2_is_last);
    assign s1_adv        = s1_valid_reg && s2_ready;
    assign s_axis_tready = !s1_valid_reg || s2_ready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // ======================= config and counters =======================
    assign in_col_last = (col_reg == last_col_reg);
    assign in_row_last = (row_reg == last_row_reg);

    always_comb
    begin
        cfg_w = 32'(cfg_data[WIDTH_REG_W-1:0]);
        cfg_h = 32'(cfg_data[HEIGHT_REG_W-1:0]);
        if (cfg_w == 32'd0)
        begin
            cfg_w = 32'd1;
        end
        if (cfg_w > 32'(MAX_WIDTH))
        begin
            cfg_w = 32'(MAX_WIDTH);
        end
        if (cfg_h == 32'd0)
        begin
            cfg_h = 32'd1;
        end
        if (cfg_h > 32'(MAX_HEIGHT))
        begin
            cfg_h = 32'(MAX_HEIGHT);
        end

        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        col_next      = col_reg;
        row_next      = row_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  last_col_next = CW'(cfg_w - 32'd1);
                REG_IMAGE_HEIGHT: last_row_next = RW'(cfg_h - 32'd1);
                default:          last_col_next = last_col_reg;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (s_fire)
        begin
            if (in_col_last)
            begin
                col_next = '0;
                row_next = in_row_last ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // ======================= line stores =======================
    // Same-column hazard only with a one-pixel-wide frame: forward from stage 1.
    assign byp      = s1_valid_reg && s1_adv && (s1_col_reg == col_reg);
    assign s1_prev  = s1_byp_reg ? s1_byp_prev_reg  : prev_rd_reg;
    assign s1_older = s1_byp_reg ? s1_byp_older_reg : older_rd_reg;

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            prev_rd_reg  <= prev_mem[col_reg];
            older_rd_reg <= older_mem[col_reg];
        end
        if (s1_adv)
        begin
            prev_mem[s1_col_reg]  <= s1_pix_reg;
            older_mem[s1_col_reg] <= s1_prev;
        end
    end

    // ======================= stage 1 payload =======================
    assign s1_valid_next = s_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_pix_reg       <= rgb_t'(s_axis_tdata);
            s1_row_reg       <= row_reg;
            s1_col_reg       <= col_reg;
            s1_row_last_reg  <= in_row_last;
            s1_col_last_reg  <= in_col_last;
            s1_byp_reg       <= byp;
            s1_byp_prev_reg  <= s1_pix_reg;
            s1_byp_older_reg <= s1_prev;
        end
    end

    // ======================= stage 2: window =======================
    // rows: 0 = r-2, 1 = r-1, 2 = r; columns: 0 = c-2, 1 = c-1, 2 = c
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= s1_older;
            win_reg[1][2] <= s1_prev;
            win_reg[2][2] <= s1_pix_reg;
            s2_row_reg    <= s1_row_reg;
            s2_col_reg    <= s1_col_reg;
            s2_r_ge1_reg  <= (s1_row_reg != '0);
            s2_r_ge2_reg  <= (s1_row_reg > RW'(1));
            s2_r_last_reg <= s1_row_last_reg;
            s2_c_ge1_reg  <= (s1_col_reg != '0);
            s2_c_ge2_reg  <= (s1_col_reg > CW'(1));
            s2_c_last_reg <= s1_col_last_reg;
        end
    end

    // Result order: row r-1 before row r, column c-1 before column c.
    // A "sel" bit of 1 picks the current row/column, present only at the edge.
    assign s1_has_res  = ((s1_row_reg != '0) || s1_row_last_reg) &&
                         ((s1_col_reg != '0) || s1_col_last_reg);
    assign s2_more_col = !s2_col_sel_reg && s2_c_last_reg;
    assign s2_more_row = !s2_row_sel_reg && s2_r_last_reg;
    assign s2_is_last  = !s2_more_col && !s2_more_row;

    always_comb
    begin
        s2_valid_next   = s2_valid_reg;
        s2_row_sel_next = s2_row_sel_reg;
        s2_col_sel_next = s2_col_sel_reg;
        if (s1_adv)
        begin
            s2_valid_next   = s1_has_res;
            s2_row_sel_next = (s1_row_reg == '0);
            s2_col_sel_next = (s1_col_reg == '0);
        end
        else if (s2_fire)
        begin
            if (s2_is_last)
            begin
                s2_valid_next = 1'b0;
            end
            else if (s2_more_col)
            begin
                s2_col_sel_next = 1'b1;
            end
            else
            begin
                s2_row_sel_next = 1'b1;
                s2_col_sel_next = !s2_c_ge1_reg;
            end
        end
    end

    // ======================= stage 2: masked sums =======================
    assign rmask[0] = !s2_row_sel_reg && s2_r_ge2_reg;
    assign rmask[1] = s2_row_sel_reg ? s2_r_ge1_reg : 1'b1;
    assign rmask[2] = 1'b1;
    assign cmask[0] = !s2_col_sel_reg && s2_c_ge2_reg;
    assign cmask[1] = s2_col_sel_reg ? s2_c_ge1_reg : 1'b1;
    assign cmask[2] = 1'b1;

    assign rcnt = {1'b0, rmask[0]} + {1'b0, rmask[1]} + {1'b0, rmask[2]};
    assign ccnt = {1'b0, cmask[0]} + {1'b0, cmask[1]} + {1'b0, cmask[2]};
    assign s2_n = {2'b00, rcnt} * {2'b00, ccnt};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rs_red[i]   = '0;
            rs_green[i] = '0;
            rs_blue[i]  = '0;
            for (int j = 0; j < 3; j++)
            begin
                if (rmask[i] && cmask[j])
                begin
                    rs_red[i]   = rs_red[i]   + SUM_W'(win_reg[i][j].red);
                    rs_green[i] = rs_green[i] + SUM_W'(win_reg[i][j].green);
                    rs_blue[i]  = rs_blue[i]  + SUM_W'(win_reg[i][j].blue);
                end
            end
        end
    end

    // sum plus half the count: round half up after the divide
    assign t_red   = rs_red[0] + rs_red[1] + rs_red[2] + SUM_W'(s2_n >> 1);
    assign t_green = rs_green[0] + rs_green[1] + rs_green[2] + SUM_W'(s2_n >> 1);
    assign t_blue  = rs_blue[0] + rs_blue[1] + rs_blue[2] + SUM_W'(s2_n >> 1);

    assign s2_a = s2_row_sel_reg ? s2_row_reg : s2_row_reg - RW'(1);
    assign s2_b = s2_col_sel_reg ? s2_col_reg : s2_col_reg - CW'(1);

    assign s3_valid_next = s2_fire ? 1'b1 : (out_ready ? 1'b0 : s3_valid_reg);

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            s3_red_reg   <= t_red;
            s3_green_reg <= t_green;
            s3_blue_reg  <= t_blue;
            s3_n_reg     <= s2_n;
            s3_row_reg   <= OUT_ROW_W'(s2_a);
            s3_col_reg   <= OUT_COL_W'(s2_b);
            s3_fend_reg  <= s2_row_sel_reg && s2_col_sel_reg;
            s3_last_reg  <= s2_is_last;
        end
    end

    // ======================= stage 3: reciprocal divide =======================
    assign s3_m       = recip(s3_n_reg);
    assign prod_red   = PROD_W'(s3_red_reg)   * PROD_W'(s3_m);
    assign prod_green = PROD_W'(s3_green_reg) * PROD_W'(s3_m);
    assign prod_blue  = PROD_W'(s3_blue_reg)  * PROD_W'(s3_m);

    assign out_valid_next = (s3_valid_reg && out_ready) ? 1'b1 :
                            (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && out_ready)
        begin
            out_data_reg <= {2'b00, s3_col_reg, s3_row_reg,
                             prod_blue[RECIP_SHIFT +: CHAN_W],
                             prod_green[RECIP_SHIFT +: CHAN_W],
                             prod_red[RECIP_SHIFT +: CHAN_W]};
            out_fend_reg <= s3_fend_reg;
            out_last_reg <= s3_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_fend_reg;
    assign m_axis_tuser  = out_last_reg;

    // ======================= control registers =======================
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg   <= CW'(RESET_W - 1);
            last_row_reg   <= RW'(RESET_H - 1);
            col_reg        <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_row_sel_reg <= 1'b0;
            s2_col_sel_reg <= 1'b0;
            s3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            last_col_reg   <= last_col_next;
            last_row_reg   <= last_row_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            s2_row_sel_reg <= s2_row_sel_next;
            s2_col_sel_reg <= s2_col_sel_next;
            s3_valid_reg   <= s3_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // ======================= assertions =======================
    `BB_ASSERT(a_col_in_range, col_reg <= last_col_reg, "column counter past row end")
    `BB_ASSERT_IMPL(a_row_sel_edge, s2_valid_reg && s2_row_sel_reg, s2_r_last_reg, "bad row sel")
    `BB_ASSERT_IMPL(a_col_sel_edge, s2_valid_reg && s2_col_sel_reg, s2_c_last_reg, "bad col sel")
    `BB_ASSERT_IMPL(a_fend_last, m_axis_tvalid && m_axis_tlast, m_axis_tuser, "early frame end")

endmodule
